// ===== design/md5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round constant and shift tables of the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam int unsigned QueueDepthDefault = 4;

  // one classified item between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5_cmd_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;
      6'd2: k = 32'h242070DB;  6'd3: k = 32'hC1BDCEEE;
      6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
      6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;
      6'd8: k = 32'h698098D8;  6'd9: k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [3:0] sel);
    logic [4:0] r;
    case (sel)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

// ===== design/md5_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_in_if / md5_out_if
// Valid/ready channels carrying message words in and digest words out.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/md5_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_queue
// Front end: accepts input words, drops empty ones, and queues the rest.
// ----------------------------------------------------------------------------
module md5_queue
  import md5_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  md5_in_if.sink   in_i,
  output md5_cmd_t cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_cmd_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic push, pop, keep;

  assign in_i.ready  = (cnt_q != Depth[AW:0]);
  assign keep        = in_i.has_byte | in_i.end_of_message;
  assign push        = in_i.valid & in_i.ready & keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{in_i.data_byte, in_i.has_byte, in_i.end_of_message};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth[AW:0]) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop from empty queue");
endmodule

// ===== design/md5_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_core
// Back end: packs bytes, pads, runs one MD5 step a cycle, emits digest words.
// ----------------------------------------------------------------------------
module md5_core
  import md5_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  md5_cmd_t cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  md5_out_if.source out_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StPad   = 3'd2;
  localparam logic [2:0] StOut   = 3'd3;

  logic [2:0]  st_q, st_d;
  logic [31:0] buf_q [16];
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [5:0]  pos_q;       // padding byte position
  logic        pad_q;       // compression belongs to padding
  logic        fin_q;       // padding block is the final one
  logic        eom_q;       // end of message waits behind a data block
  logic [1:0]  oidx_q;

  logic [5:0]  bpos;
  logic [1:0]  grp;
  logic [3:0]  g;
  logic [31:0] f, t, rot, bnew;
  logic [4:0]  sh;

  assign bpos = len_q[8:3];
  assign grp  = rnd_q[5:4];
  assign cmd_ready_o = (st_q == StIdle);

  always_comb begin
    case (grp)
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = rnd_q[3:0]; end
      2'd1: begin f = (b_q & d_q) | (c_q & ~d_q); g = 4'(5 * rnd_q + 1); end
      2'd2: begin f = b_q ^ c_q ^ d_q;            g = 4'(3 * rnd_q + 5); end
      default: begin f = c_q ^ (b_q | ~d_q);      g = 4'(7 * rnd_q); end
    endcase
    sh   = md5_rot({grp, rnd_q[1:0]});
    t    = a_q + f + buf_q[g] + md5_k(rnd_q);
    rot  = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
    bnew = b_q + rot;
  end

  assign out_o.valid       = (st_q == StOut);
  assign out_o.digest_word = h_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == 2'd3);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (cmd_valid_i) begin
        if (cmd_i.has_byte && bpos == 6'd63) st_d = StRound;
        else if (cmd_i.end_of_message) st_d = StPad;
      end
      StRound: if (rnd_q == 6'd63) st_d = (pad_q || eom_q) ?
                                   ((fin_q && pad_q) ? StOut : StPad) : StIdle;
      StPad: if (pos_q == 6'd63) st_d = StRound;
      StOut: if (out_o.ready && oidx_q == 2'd3) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // byte, padding and length writes into the block buffer
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_valid_i && cmd_i.has_byte) begin
      if (bpos[1:0] == 2'd0) buf_q[bpos[5:2]] <= {24'd0, cmd_i.data_byte};
      else buf_q[bpos[5:2]][bpos[1:0]*8 +: 8] <= cmd_i.data_byte;
    end else if (st_q == StPad) begin
      if (pos_q >= 6'd56 && fin_q) begin
        if (pos_q == 6'd56) begin
          buf_q[14] <= len_q[31:0];
          buf_q[15] <= len_q[63:32];
        end
      end else if (pos_q[1:0] == 2'd0) begin
        buf_q[pos_q[5:2]] <= {24'd0, pad_q ? 8'h00 : 8'h80};
      end else begin
        buf_q[pos_q[5:2]][pos_q[1:0]*8 +: 8] <= pad_q ? 8'h00 : 8'h80;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      h_q    <= '{InitA, InitB, InitC, InitD};
      len_q  <= '0;
      rnd_q  <= '0;
      pos_q  <= '0;
      pad_q  <= 1'b0;
      fin_q  <= 1'b0;
      eom_q  <= 1'b0;
      oidx_q <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        StIdle: if (cmd_valid_i) begin
          if (cmd_i.has_byte) len_q <= len_q + 64'd8;
          // the 0x80 goes at the position after any byte on this word
          pos_q <= cmd_i.has_byte ? bpos + 6'd1 : bpos;
          pad_q <= 1'b0;
          fin_q <= (cmd_i.has_byte ? {1'b0, bpos} + 7'd1 : {1'b0, bpos}) < 7'd56;
          eom_q <= cmd_i.end_of_message;
          rnd_q <= '0;
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
        end
        StPad: begin
          pad_q <= 1'b1;
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd63) begin
            rnd_q <= '0;
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
          end
        end
        StRound: begin
          a_q <= d_q; b_q <= bnew; c_q <= b_q; d_q <= c_q;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            h_q[0] <= h_q[0] + d_q;
            h_q[1] <= h_q[1] + bnew;
            h_q[2] <= h_q[2] + b_q;
            h_q[3] <= h_q[3] + c_q;
            // after a full data block the padding restarts at position zero
            if (!pad_q) begin
              pos_q <= '0;
              fin_q <= 1'b1;
            end else begin
              pos_q <= '0;
              fin_q <= 1'b1;
            end
          end
        end
        StOut: if (out_o.ready) begin
          oidx_q <= oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            h_q   <= '{InitA, InitB, InitC, InitD};
            len_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_out_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !cmd_ready_o) else $error("output while taking input");
  a_len_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.last_word |=> len_q == '0)
    else $error("length not cleared");
  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIdle |-> oidx_q == 2'd0) else $error("digest index stuck");
endmodule

// ===== design/md5_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 hash over a byte stream, digest given as four 32-bit words.
// ----------------------------------------------------------------------------
// A byte word is taken and queued; the back end stores it while idle. The
// 64th byte of a block starts compression, one MD5 step per cycle through a
// single round unit. An end word pads one byte a cycle to the end of the
// block, compresses, maybe pads and compresses a second block, then offers
// the four digest words one per cycle while the receiver is ready.
module md5_message_digest
  import md5_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);
  md5_cmd_t cmd;
  logic     cmd_valid, cmd_ready;

  md5_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .in_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  md5_core u_core (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .out_o
  );
endmodule
